[src/slps_pkg.sv]
// ----------------------------------------------------------------------------
// slps_pkg - shared definitions for the status LED pattern sequencer
// Mode and register codes, pattern timing constants and the sweep table.
// ----------------------------------------------------------------------------
package slps_pkg;

    localparam int COLOR_W   = 3;
    localparam int MODE_W    = 4;
    localparam int TICK_W    = 16;
    localparam int RUN_W     = 17;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // register indices on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_COLOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEADY         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FOREVER = 3'd5;

    // modes
    localparam logic [MODE_W-1:0] MODE_MANUAL     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_OPENING    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_AUTONOMOUS = 4'd2;
    localparam logic [MODE_W-1:0] MODE_TELEOP     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_WANDER     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_LOW_BATT   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CHARGING   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_CHARGED    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_ERROR      = 4'd8;

    // colours
    localparam logic [COLOR_W-1:0] COL_OFF       = 3'd0;
    localparam logic [COLOR_W-1:0] COL_RED       = 3'd1;
    localparam logic [COLOR_W-1:0] COL_GREEN     = 3'd2;
    localparam logic [COLOR_W-1:0] COL_YELLOW    = 3'd3;
    localparam logic [COLOR_W-1:0] COL_BLUE      = 3'd4;
    localparam logic [COLOR_W-1:0] COL_TURQUOISE = 3'd6;

    // timing in 10 ms ticks
    localparam logic [TICK_W-1:0] TICKS_STROBE     = 16'd5;
    localparam logic [TICK_W-1:0] TICKS_GAP_AUTO   = 16'd20;
    localparam logic [TICK_W-1:0] TICKS_GAP_FLIP   = 16'd50;
    localparam logic [TICK_W-1:0] TICKS_SWEEP      = 16'd50;
    localparam logic [TICK_W-1:0] TICKS_SLOW_HALF  = 16'd50;
    localparam logic [TICK_W-1:0] TICKS_STEADY_RUN = 16'd10;
    localparam logic [TICK_W-1:0] TICKS_ONE        = 16'd1;
    localparam logic [RUN_W-1:0]  RUN_TICKS_MAX    = 17'h1FFFF;

    localparam logic [STEP_W-1:0] STEPS_SWEEP  = 5'd14;
    localparam logic [STEP_W-1:0] STEPS_AUTO   = 5'd16;
    localparam logic [STEP_W-1:0] STEPS_STROBE = 5'd14;
    localparam logic [STEP_W-1:0] STEPS_FLASH  = 5'd2;
    localparam logic [STEP_W-1:0] STEPS_ONE    = 5'd1;
    localparam logic [STEP_W-1:0] STEP_AUTO_A  = 5'd7;
    localparam logic [STEP_W-1:0] STEP_AUTO_B  = 5'd15;
    localparam logic [STEP_W-1:0] STEP_FLIP    = 5'd13;
    localparam logic [STEP_W-1:0] STEP_AUTO_SW = 5'd8;

    // opening sweep, indexed by the low four bits of the step index
    localparam logic [COLOR_W-1:0] SWEEP_COLORS [16] = '{
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd6,
        3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd1, 3'd2
    };

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [TICK_W-1:0]  len;
        logic [STEP_W-1:0]  count;
        logic [RUN_W-1:0]   pad_target;
    } pattern_t;

endpackage

[src/status_led_pattern_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer_unit - RGB status LED pattern sequencer
// The result beat is registered and appears in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle while the result side is ready; the output register frees as it drains.
// The per-tick update is one pass of logic between the state and output regs.
// Reset: synchronous, active low; state, config and valid registers return to their defaults, LED off.
// ----------------------------------------------------------------------------
// Stream sequencer: one input beat per 10 ms tick, one LED result beat each.
// ----------------------------------------------------------------------------
module status_led_pattern_sequencer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] restart
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [0] red [1] green [2] blue
                                                       // [3] active [4] run_done
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [slps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slps_pkg::CFG_DAT_W-1:0]  cfg_data
);

    logic [slps_pkg::MODE_W-1:0]  mode_reg;
    logic [slps_pkg::COLOR_W-1:0] manual_color_reg;
    logic [slps_pkg::TICK_W-1:0]  half_period_reg;
    logic                         steady_reg;
    logic [slps_pkg::TICK_W-1:0]  repeat_count_reg;
    logic                         repeat_forever_reg;

    logic [slps_pkg::TICK_W-1:0]  runs_left_reg, runs_left_next;
    logic [slps_pkg::STEP_W-1:0]  step_index_reg, step_index_next;
    logic [slps_pkg::TICK_W-1:0]  step_ticks_reg, step_ticks_next;
    logic [slps_pkg::RUN_W-1:0]   run_ticks_reg, run_ticks_next;
    logic                         padding_reg, padding_next;
    logic [slps_pkg::COLOR_W-1:0] shown_color_reg, shown_color_next;

    logic                         out_valid_reg;
    logic [4:0]                   out_data_reg;

    logic                         s_accept;
    logic                         restart;
    logic                         active;
    logic                         done;
    logic                         finished;
    logic [slps_pkg::TICK_W-1:0]  half_eff;
    logic [slps_pkg::STEP_W-1:0]  step_index_cur;
    slps_pkg::pattern_t           pat;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign restart   = s_tdata[0];
    assign half_eff  = (half_period_reg == '0) ? slps_pkg::TICKS_ONE : half_period_reg;
    assign step_index_cur = restart ? '0 : step_index_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

    slps_pattern u_pattern (
        .mode         (mode_reg),
        .manual_color (manual_color_reg),
        .half_eff     (half_eff),
        .steady       (steady_reg),
        .step_index   (step_index_cur),
        .pat          (pat)
    );

    always_comb begin
        runs_left_next   = restart ? repeat_count_reg : runs_left_reg;
        step_index_next  = step_index_cur;
        step_ticks_next  = restart ? '0 : step_ticks_reg;
        run_ticks_next   = restart ? '0 : run_ticks_reg;
        padding_next     = restart ? 1'b0 : padding_reg;
        shown_color_next = shown_color_reg;
        done             = 1'b0;
        finished         = 1'b0;
        active           = repeat_forever_reg || (runs_left_next != '0);

        if (!active) begin
            step_index_next  = '0;
            step_ticks_next  = '0;
            run_ticks_next   = '0;
            padding_next     = 1'b0;
            shown_color_next = slps_pkg::COL_OFF;
        end else begin
            if (run_ticks_next < slps_pkg::RUN_TICKS_MAX)
                run_ticks_next = run_ticks_next + 1'b1;
            if (!padding_next) begin
                if (step_index_next < pat.count) begin
                    shown_color_next = pat.color;
                    step_ticks_next  = step_ticks_next + 1'b1;
                    if (step_ticks_next >= pat.len) begin
                        step_ticks_next = '0;
                        step_index_next = step_index_next + 1'b1;
                    end
                    finished = (step_index_next >= pat.count);
                end else begin
                    finished = 1'b1;
                end
                if (finished) begin
                    if (run_ticks_next >= pat.pad_target)
                        done = 1'b1;
                    else
                        padding_next = 1'b1;
                end
            end else if (run_ticks_next >= pat.pad_target) begin
                done = 1'b1;
            end
            if (done) begin
                if (!repeat_forever_reg && runs_left_next != '0)
                    runs_left_next = runs_left_next - 1'b1;
                step_index_next = '0;
                step_ticks_next = '0;
                run_ticks_next  = '0;
                padding_next    = 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= slps_pkg::MODE_MANUAL;
            manual_color_reg   <= slps_pkg::COL_OFF;
            half_period_reg    <= 16'd5;
            steady_reg         <= 1'b0;
            repeat_count_reg   <= '0;
            repeat_forever_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                slps_pkg::REG_MODE:           mode_reg <= cfg_data[slps_pkg::MODE_W-1:0];
                slps_pkg::REG_MANUAL_COLOR:   manual_color_reg <= cfg_data[slps_pkg::COLOR_W-1:0];
                slps_pkg::REG_HALF_PERIOD:    half_period_reg <= cfg_data;
                slps_pkg::REG_STEADY:         steady_reg <= cfg_data[0];
                slps_pkg::REG_REPEAT_COUNT:   repeat_count_reg <= cfg_data;
                slps_pkg::REG_REPEAT_FOREVER: repeat_forever_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            runs_left_reg   <= '0;
            step_index_reg  <= '0;
            step_ticks_reg  <= '0;
            run_ticks_reg   <= '0;
            padding_reg     <= 1'b0;
            shown_color_reg <= slps_pkg::COL_OFF;
        end else if (s_accept) begin
            runs_left_reg   <= runs_left_next;
            step_index_reg  <= step_index_next;
            step_ticks_reg  <= step_ticks_next;
            run_ticks_reg   <= run_ticks_next;
            padding_reg     <= padding_next;
            shown_color_reg <= shown_color_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_data_reg <= {done, active, shown_color_next};
        end
    end

    property p_done_needs_active;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid && m_tdata[4] |-> m_tdata[3];
    endproperty
    a_done_needs_active: assert property (p_done_needs_active)
        else $error("run_done without active");

    property p_idle_led_off;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid && !m_tdata[3] |-> (m_tdata[2:0] == slps_pkg::COL_OFF);
    endproperty
    a_idle_led_off: assert property (p_idle_led_off)
        else $error("LED lit while inactive");

    property p_step_bound;
        @(posedge aclk) disable iff (!aresetn)
            step_index_reg <= slps_pkg::STEPS_AUTO;
    endproperty
    a_step_bound: assert property (p_step_bound)
        else $error("step index beyond longest pattern");

    property p_done_clears;
        @(posedge aclk) disable iff (!aresetn)
            s_accept && done |=> (step_index_reg == '0) && !padding_reg &&
                                 (run_ticks_reg == '0);
    endproperty
    a_done_clears: assert property (p_done_clears)
        else $error("run state not cleared at end of run");

    property p_hold_stalled;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                     $stable(runs_left_reg);
    endproperty
    a_hold_stalled: assert property (p_hold_stalled)
        else $error("state moved while result stalled");

endmodule

[src/slps_pattern.sv]
// ----------------------------------------------------------------------------
// slps_pattern - pattern step lookup
// Colour and length of the current step, step count and run pad target.
// ----------------------------------------------------------------------------
module slps_pattern (
    input  logic [slps_pkg::MODE_W-1:0]  mode,
    input  logic [slps_pkg::COLOR_W-1:0] manual_color,
    input  logic [slps_pkg::TICK_W-1:0]  half_eff,
    input  logic                         steady,
    input  logic [slps_pkg::STEP_W-1:0]  step_index,
    output slps_pkg::pattern_t           pat
);

    always_comb begin
        pat.color      = slps_pkg::COL_OFF;
        pat.len        = slps_pkg::TICKS_ONE;
        pat.count      = slps_pkg::STEPS_ONE;
        pat.pad_target = {half_eff, 1'b0};
        unique case (mode)
            slps_pkg::MODE_MANUAL: begin
                if (steady) begin
                    pat.color = manual_color;
                    pat.len   = slps_pkg::TICKS_STEADY_RUN;
                    pat.count = slps_pkg::STEPS_ONE;
                end else begin
                    pat.color = (step_index == '0) ? manual_color : slps_pkg::COL_OFF;
                    pat.len   = half_eff;
                    pat.count = slps_pkg::STEPS_FLASH;
                end
            end
            slps_pkg::MODE_OPENING: begin
                pat.color = slps_pkg::SWEEP_COLORS[step_index[3:0]];
                pat.len   = slps_pkg::TICKS_SWEEP;
                pat.count = slps_pkg::STEPS_SWEEP;
            end
            slps_pkg::MODE_AUTONOMOUS: begin
                if (step_index[0])
                    pat.color = slps_pkg::COL_OFF;
                else if (step_index < slps_pkg::STEP_AUTO_SW)
                    pat.color = slps_pkg::COL_RED;
                else
                    pat.color = slps_pkg::COL_BLUE;
                pat.len = (step_index == slps_pkg::STEP_AUTO_A ||
                           step_index == slps_pkg::STEP_AUTO_B)
                          ? slps_pkg::TICKS_STROBE + slps_pkg::TICKS_GAP_AUTO
                          : slps_pkg::TICKS_STROBE;
                pat.count = slps_pkg::STEPS_AUTO;
            end
            slps_pkg::MODE_TELEOP, slps_pkg::MODE_WANDER: begin
                if (step_index[0])
                    pat.color = slps_pkg::COL_OFF;
                else if (mode == slps_pkg::MODE_TELEOP)
                    pat.color = slps_pkg::COL_BLUE;
                else
                    pat.color = slps_pkg::COL_TURQUOISE;
                pat.len = (step_index == slps_pkg::STEP_FLIP)
                          ? slps_pkg::TICKS_STROBE + slps_pkg::TICKS_GAP_FLIP
                          : slps_pkg::TICKS_STROBE;
                pat.count = slps_pkg::STEPS_STROBE;
            end
            slps_pkg::MODE_LOW_BATT, slps_pkg::MODE_CHARGING, slps_pkg::MODE_ERROR: begin
                if (step_index != '0)
                    pat.color = slps_pkg::COL_OFF;
                else if (mode == slps_pkg::MODE_LOW_BATT)
                    pat.color = slps_pkg::COL_YELLOW;
                else if (mode == slps_pkg::MODE_CHARGING)
                    pat.color = slps_pkg::COL_GREEN;
                else
                    pat.color = slps_pkg::COL_RED;
                pat.len   = slps_pkg::TICKS_SLOW_HALF;
                pat.count = slps_pkg::STEPS_FLASH;
            end
            slps_pkg::MODE_CHARGED: begin
                pat.color = slps_pkg::COL_GREEN;
                pat.len   = slps_pkg::TICKS_ONE;
                pat.count = slps_pkg::STEPS_ONE;
            end
            default: begin
                pat.color = slps_pkg::COL_OFF;
                pat.len   = slps_pkg::TICKS_ONE;
                pat.count = slps_pkg::STEPS_ONE;
            end
        endcase
        if (mode == slps_pkg::MODE_TELEOP || mode == slps_pkg::MODE_WANDER || steady)
            pat.pad_target = '0;
    end

endmodule

[verif/tb_status_led_pattern_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// tb_status_led_pattern_sequencer_unit - self-checking bench for the LED sequencer
// A short table of directed beats, then random phases of register settings and
// tick beats. The bench keeps its own model of the sequencer, predicts the LED
// beat for every accepted tick and checks the result stream in order. Both
// stream sides idle at random, and the result side holds off once for a long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_status_led_pattern_sequencer_unit;

    localparam logic [slps_pkg::MODE_W-1:0] MODE_UNKNOWN = 4'd15;
    localparam int TICK_TARGET = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0] pad;
        logic       run_done;
        logic       active;
        logic       blue;
        logic       green;
        logic       red;
    } led_beat_t;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [slps_pkg::CFG_IDX_W-1:0]   idx;
        logic [slps_pkg::CFG_DAT_W-1:0]   data;
        logic                             restart;
        logic                             fixed;
        led_beat_t                        want;
    } plan_row_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata   = 8'h00;   // [0] restart
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [7:0]                       m_tdata;             // [0] red [1] green [2] blue
                                                           // [3] active [4] run_done
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [slps_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [slps_pkg::CFG_DAT_W-1:0]   cfg_data  = '0;

    status_led_pattern_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // register copies
    logic [slps_pkg::MODE_W-1:0]  mode_q;
    logic [slps_pkg::COLOR_W-1:0] color_q;
    logic [slps_pkg::TICK_W-1:0]  half_q;
    logic                         steady_q;
    logic [slps_pkg::TICK_W-1:0]  repeats_q;
    logic                         forever_q;

    // sequencer state
    logic [slps_pkg::TICK_W-1:0]  runs_pending;
    logic [slps_pkg::STEP_W-1:0]  step_no;
    logic [slps_pkg::TICK_W-1:0]  step_age;
    logic [slps_pkg::RUN_W-1:0]   run_age;
    logic                         in_pad;
    logic [slps_pkg::COLOR_W-1:0] lit_color;

    led_beat_t led_expected [$];
    int        fail_count  = 0;
    int        ticks_sent  = 0;
    bit        no_idle     = 1'b0;
    bit        hold_req    = 1'b0;

    localparam logic [slps_pkg::COLOR_W-1:0] SWEEP_ORDER [14] = '{
        slps_pkg::COL_RED, slps_pkg::COL_GREEN, slps_pkg::COL_YELLOW,
        slps_pkg::COL_BLUE, 3'd5, slps_pkg::COL_TURQUOISE, 3'd7,
        slps_pkg::COL_TURQUOISE, 3'd5, slps_pkg::COL_BLUE, slps_pkg::COL_YELLOW,
        slps_pkg::COL_GREEN, slps_pkg::COL_RED, slps_pkg::COL_OFF
    };

    function automatic logic [slps_pkg::TICK_W-1:0] half_ticks();
        return (half_q == '0) ? 16'd1 : half_q;
    endfunction

    function automatic logic [slps_pkg::STEP_W-1:0] steps_in_mode();
        unique case (mode_q)
            slps_pkg::MODE_MANUAL:
                return steady_q ? 5'd1 : 5'd2;
            slps_pkg::MODE_OPENING, slps_pkg::MODE_TELEOP, slps_pkg::MODE_WANDER:
                return 5'd14;
            slps_pkg::MODE_AUTONOMOUS:
                return 5'd16;
            slps_pkg::MODE_LOW_BATT, slps_pkg::MODE_CHARGING, slps_pkg::MODE_ERROR:
                return 5'd2;
            default:
                return 5'd1;
        endcase
    endfunction

    function automatic void step_shape(input logic [slps_pkg::STEP_W-1:0] i,
                                       output logic [slps_pkg::COLOR_W-1:0] col,
                                       output logic [slps_pkg::TICK_W-1:0] len);
        unique case (mode_q)
            slps_pkg::MODE_MANUAL: begin
                if (steady_q) begin
                    col = color_q;
                    len = 16'd10;
                end else begin
                    col = (i == 0) ? color_q : slps_pkg::COL_OFF;
                    len = half_ticks();
                end
            end
            slps_pkg::MODE_OPENING: begin
                col = SWEEP_ORDER[i % 14];
                len = 16'd50;
            end
            slps_pkg::MODE_AUTONOMOUS: begin
                col = i[0] ? slps_pkg::COL_OFF
                           : ((i < 8) ? slps_pkg::COL_RED : slps_pkg::COL_BLUE);
                len = (i == 7 || i == 15) ? 16'd25 : 16'd5;
            end
            slps_pkg::MODE_TELEOP, slps_pkg::MODE_WANDER: begin
                if (i[0])                                col = slps_pkg::COL_OFF;
                else if (mode_q == slps_pkg::MODE_TELEOP) col = slps_pkg::COL_BLUE;
                else                                     col = slps_pkg::COL_TURQUOISE;
                len = (i == 13) ? 16'd55 : 16'd5;
            end
            slps_pkg::MODE_LOW_BATT, slps_pkg::MODE_CHARGING, slps_pkg::MODE_ERROR: begin
                if (i != 0)                                 col = slps_pkg::COL_OFF;
                else if (mode_q == slps_pkg::MODE_LOW_BATT) col = slps_pkg::COL_YELLOW;
                else if (mode_q == slps_pkg::MODE_CHARGING) col = slps_pkg::COL_GREEN;
                else                                        col = slps_pkg::COL_RED;
                len = 16'd50;
            end
            slps_pkg::MODE_CHARGED: begin
                col = slps_pkg::COL_GREEN;
                len = 16'd1;
            end
            default: begin
                col = slps_pkg::COL_OFF;
                len = 16'd1;
            end
        endcase
    endfunction

    function automatic void clear_run_state();
        step_no  = '0;
        step_age = '0;
        run_age  = '0;
        in_pad   = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [slps_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [slps_pkg::CFG_DAT_W-1:0] data);
        unique case (idx)
            slps_pkg::REG_MODE:           mode_q    = data[slps_pkg::MODE_W-1:0];
            slps_pkg::REG_MANUAL_COLOR:   color_q   = data[slps_pkg::COLOR_W-1:0];
            slps_pkg::REG_HALF_PERIOD:    half_q    = data;
            slps_pkg::REG_STEADY:         steady_q  = data[0];
            slps_pkg::REG_REPEAT_COUNT:   repeats_q = data;
            slps_pkg::REG_REPEAT_FOREVER: forever_q = data[0];
            default: ;
        endcase
    endfunction

    function automatic led_beat_t advance_tick(input logic restart);
        logic [slps_pkg::STEP_W-1:0]  nsteps;
        logic [slps_pkg::COLOR_W-1:0] col;
        logic [slps_pkg::TICK_W-1:0]  len;
        logic [slps_pkg::RUN_W-1:0]   goal;
        logic                         act;
        logic                         fin;
        logic                         done;
        led_beat_t                    r;
        fin  = 1'b0;
        done = 1'b0;
        if (restart) begin
            runs_pending = repeats_q;
            clear_run_state();
        end
        act = forever_q || (runs_pending != 0);
        if (!act) begin
            clear_run_state();
            lit_color = slps_pkg::COL_OFF;
        end else begin
            if (mode_q == slps_pkg::MODE_TELEOP || mode_q == slps_pkg::MODE_WANDER || steady_q)
                goal = '0;
            else
                goal = {half_ticks(), 1'b0};
            if (run_age != slps_pkg::RUN_TICKS_MAX) run_age = run_age + 1'b1;
            if (!in_pad) begin
                nsteps = steps_in_mode();
                if (step_no < nsteps) begin
                    step_shape(step_no, col, len);
                    lit_color = col;
                    step_age  = step_age + 1'b1;
                    if (step_age >= len) begin
                        step_age = '0;
                        step_no  = step_no + 1'b1;
                    end
                    if (step_no >= nsteps) fin = 1'b1;
                end else begin
                    fin = 1'b1;
                end
                if (fin) begin
                    if (run_age >= goal) done = 1'b1;
                    else                 in_pad = 1'b1;
                end
            end else if (run_age >= goal) begin
                done = 1'b1;
            end
            if (done) begin
                if (!forever_q && runs_pending != 0) runs_pending = runs_pending - 1'b1;
                clear_run_state();
            end
        end
        r          = '0;
        r.red      = lit_color[0];
        r.green    = lit_color[1];
        r.blue     = lit_color[2];
        r.active   = act;
        r.run_done = done;
        return r;
    endfunction

    task automatic write_reg(input logic [slps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slps_pkg::CFG_DAT_W-1:0] data);
        s_tvalid <= 1'b0;
        while (led_expected.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic send_tick(input logic restart, input logic fixed, input led_beat_t want);
        int        gap;
        led_beat_t pred;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge aclk); while (!s_tready);
        pred = advance_tick(restart);
        led_expected.push_back(fixed ? want : pred);
        ticks_sent++;
    endtask

    task automatic report(input string field, input int want, input int got);
        fail_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // result side
    initial begin
        int        gap;
        led_beat_t got;
        led_beat_t want;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 19);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata;
            if (led_expected.size() == 0) begin
                report("unexpected beat", 0, int'(got));
            end else begin
                want = led_expected.pop_front();
                if (got.red      !== want.red)      report("red", want.red, got.red);
                if (got.green    !== want.green)    report("green", want.green, got.green);
                if (got.blue     !== want.blue)     report("blue", want.blue, got.blue);
                if (got.active   !== want.active)   report("active", want.active, got.active);
                if (got.run_done !== want.run_done) report("run_done", want.run_done, got.run_done);
                if (got.pad      !== want.pad)      report("pad", want.pad, got.pad);
            end
        end
    end

    initial begin
        #(12 * 600000);
        $display("tb_status_led_pattern_sequencer_unit: errors");
        $finish;
    end

    // stimulus
    initial begin
        plan_row_t                      plan [$];
        int                             phase;
        int                             n_ticks;
        logic [slps_pkg::CFG_DAT_W-1:0] v;

        mode_q = slps_pkg::MODE_MANUAL; color_q = slps_pkg::COL_OFF; half_q = 16'd5;
        steady_q = 1'b0; repeats_q = '0; forever_q = 1'b0;
        runs_pending = '0;
        clear_run_state();
        lit_color = slps_pkg::COL_OFF;

        plan = '{
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b0, 1'b1, 8'h00},   // idle after reset
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b1, 8'h00},   // restart, no runs
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_CHARGED), 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_REPEAT_COUNT, 16'd1, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_STEADY, 16'd1, 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b1, 8'h1A},   // green, run over
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b0, 1'b1, 8'h00},   // count spent
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_MANUAL), 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MANUAL_COLOR, 16'd7, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_STEADY, 16'd0, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_HALF_PERIOD, 16'd0, 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b1, 8'h0F},   // zero half period
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b0, 1'b1, 8'h18},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b0, 1'b1, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(MODE_UNKNOWN), 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_REPEAT_FOREVER, 16'd1, 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b1, 8'h08},   // unknown mode
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b0, 1'b1, 8'h18},
            '{ROW_CFG,  slps_pkg::REG_HALF_PERIOD, 16'hFFFF, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MANUAL_COLOR, 16'd5, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_MANUAL), 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_REPEAT_COUNT, 16'hFFFF, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_REPEAT_FOREVER, 16'd0, 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_OPENING), 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_AUTONOMOUS), 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_TELEOP), 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_WANDER), 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_LOW_BATT), 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_CHARGING), 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  slps_pkg::REG_MODE, 16'(slps_pkg::MODE_ERROR), 1'b0, 1'b0, 8'h00},
            '{ROW_TICK, slps_pkg::REG_MODE, 16'd0, 1'b1, 1'b0, 8'h00}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) write_reg(plan[k].idx, plan[k].data);
            else                         send_tick(plan[k].restart, plan[k].fixed, plan[k].want);
        end

        // random phases; state carries over when a phase does not restart
        phase = 0;
        while (ticks_sent < TICK_TARGET) begin
            phase++;
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1) == 1)
                write_reg(slps_pkg::REG_MODE,
                          16'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                          : $urandom_range(0, 8)));
            if ($urandom_range(0, 1) == 1)
                write_reg(slps_pkg::REG_MANUAL_COLOR, 16'($urandom_range(0, 7)));
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 9))
                    0:       v = 16'd0;
                    1:       v = 16'($urandom_range(13, 300));
                    2:       v = 16'($urandom_range(0, 65535));
                    default: v = 16'($urandom_range(1, 12));
                endcase
                write_reg(slps_pkg::REG_HALF_PERIOD, v);
            end
            if ($urandom_range(0, 1) == 1)
                write_reg(slps_pkg::REG_STEADY, 16'($urandom_range(0, 3) == 0));
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 9))
                    0, 1:    v = 16'd0;
                    2:       v = 16'($urandom_range(5, 20));
                    3:       v = 16'($urandom_range(0, 65535));
                    default: v = 16'($urandom_range(1, 4));
                endcase
                write_reg(slps_pkg::REG_REPEAT_COUNT, v);
            end
            if ($urandom_range(0, 1) == 1)
                write_reg(slps_pkg::REG_REPEAT_FOREVER, 16'($urandom_range(0, 4) == 0));

            if (phase == 3) begin
                no_idle  = 1'b1;
                hold_req = 1'b1;
            end
            n_ticks = (mode_q == slps_pkg::MODE_OPENING) ? $urandom_range(100, 800)
                                                         : $urandom_range(20, 250);
            if (n_ticks > TICK_TARGET - ticks_sent)
                n_ticks = TICK_TARGET - ticks_sent;
            for (int i = 0; i < n_ticks; i++)
                send_tick((i == 0 && $urandom_range(0, 7) != 0) || $urandom_range(0, 60) == 0,
                          1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (led_expected.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        fail_count += led_expected.size();
        if (fail_count == 0)
            $display("tb_status_led_pattern_sequencer_unit: clean");
        else
            $display("tb_status_led_pattern_sequencer_unit: errors");
        $finish;
    end

endmodule
